### rtl/core/tst_pkg.sv
// Shared types and codes of the timer slot table.
package tst_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int SLOT_W    = 4;

    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_REGISTER = 1'b1;

    localparam logic [1:0] KIND_ONESHOT  = 2'd0;
    localparam logic [1:0] KIND_PERIODIC = 2'd1;

    localparam logic [1:0] RK_REPLY = 2'd0;
    localparam logic [1:0] RK_FIRE  = 2'd1;
    localparam logic [1:0] RK_DONE  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  kind;
        logic [31:0] period;
        logic [7:0]  handler_id;
        logic [31:0] user_word;
    } req_word_t;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        fired_handler;
        logic [31:0]       fired_word;
        logic              last;
    } evt_word_t;

    typedef struct packed {
        logic        periodic;
        logic [31:0] period;
        logic [31:0] deadline;
        logic [7:0]  handler;
        logic [31:0] word;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RSCAN,
        S_REPLY,
        S_TREAD,
        S_TCHECK,
        S_TDONE
    } state_t;

endpackage

### rtl/core/tst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/timer_slot_table.sv
// Timer slot table: register and tick sequencer over a slot RAM.
//
//  channel   direction  handshake                word type
//  req       in         req_valid / req_ready    req_word_t
//  evt       out        evt_valid / evt_ready    evt_word_t
//
// One word is worked at a time; req_ready is high only while the sequencer idles
// and the output register is empty or hands its word out in that cycle.
// Register: a valid word scans the active bits serially for a free slot.
// Tick: one RAM read and one deadline compare per slot on the shared adder and
// comparator.
// A waiting reply, fire or done word stalls the sequencer while evt_ready holds it back.
// Reset clears the tick count and all active bits at once; no clearing pass is needed.
module timer_slot_table
    import tst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req_word,
    output logic      evt_valid,
    input  logic      evt_ready,
    output evt_word_t evt_word
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

    state_t            state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [31:0]       tick_reg, tick_next;
    logic [SLOTS-1:0]  active_reg, active_next;
    req_word_t         cur_reg, cur_next;
    logic              out_valid_reg, out_valid_next;
    evt_word_t         out_reg, out_next;

    logic              ram_we;
    logic              ram_re;
    slot_entry_t       ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    slot_entry_t       rd;

    logic              out_free;
    logic              req_take;
    logic              req_bad;
    logic [31:0]       add_b;
    logic [31:0]       add_sum;
    logic              hit;

    tst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd        = slot_entry_t'(ram_rdata);
    assign out_free  = !out_valid_reg || evt_ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign req_take  = req_valid && req_ready;
    assign req_bad   = (req_word.kind != KIND_ONESHOT && req_word.kind != KIND_PERIODIC)
                       || (req_word.period == 32'd0) || (req_word.handler_id == 8'd0);

    // shared adder: tick advance, new deadline, re-arm deadline
    always_comb
    begin
        case (state_reg)
            S_IDLE:  add_b = 32'd1;
            S_RSCAN: add_b = cur_reg.period;
            default: add_b = rd.period;
        endcase
    end
    assign add_sum = tick_reg + add_b;
    assign hit     = active_reg[idx_reg] && (rd.deadline == tick_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        tick_next      = tick_reg;
        active_next    = active_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !evt_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wdata      = rd;

        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    cur_next = req_word;
                    idx_next = '0;
                    if (req_word.cmd == CMD_TICK)
                    begin
                        tick_next  = add_sum;
                        state_next = S_TREAD;
                    end
                    else if (req_bad)
                    begin
                        out_next   = '{RK_REPLY, ST_INVAL, '0, 8'd0, 32'd0, 1'b1};
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        state_next = S_RSCAN;
                    end
                end
            end
            S_RSCAN:
            begin
                if (!active_reg[idx_reg])
                begin
                    ram_we               = 1'b1;
                    ram_wdata.periodic   = (cur_reg.kind == KIND_PERIODIC);
                    ram_wdata.period     = cur_reg.period;
                    ram_wdata.deadline   = add_sum;
                    ram_wdata.handler    = cur_reg.handler_id;
                    ram_wdata.word       = cur_reg.user_word;
                    active_next[idx_reg] = 1'b1;
                    out_next   = '{RK_REPLY, ST_OK, SLOT_W'(idx_reg), 8'd0, 32'd0, 1'b1};
                    state_next = S_REPLY;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    out_next   = '{RK_REPLY, ST_FULL, '0, 8'd0, 32'd0, 1'b1};
                    state_next = S_REPLY;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_TREAD:
            begin
                ram_re     = 1'b1;
                state_next = S_TCHECK;
            end
            S_TCHECK:
            begin
                // a firing slot waits here until the output register frees up
                if (!hit || out_free)
                begin
                    if (hit)
                    begin
                        out_valid_next = 1'b1;
                        out_next = '{RK_FIRE, ST_OK, SLOT_W'(idx_reg), rd.handler, rd.word,
                                     1'b0};
                        if (rd.periodic)
                        begin
                            ram_we             = 1'b1;
                            ram_wdata.deadline = add_sum;
                        end
                        else
                        begin
                            active_next[idx_reg] = 1'b0;
                        end
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = S_TDONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_TREAD;
                    end
                end
            end
            S_TDONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{RK_DONE, ST_OK, '0, 8'd0, 32'd0, 1'b1};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            tick_reg      <= 32'd0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            tick_reg      <= tick_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign evt_valid = out_valid_reg;
    assign evt_word  = out_reg;

    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> !(evt_word.last && evt_word.result_kind == RK_FIRE))
        else $error("fire word flagged as last");

    a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == S_RSCAN) |-> !active_reg[idx_reg])
        else $error("register claimed an active slot");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_RSCAN || (state_reg == S_TCHECK && hit)))
        else $error("slot RAM written outside register claim or re-arm");

    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_reg != $past(tick_reg)) |->
            $past(req_valid && req_ready && req_word.cmd == CMD_TICK))
        else $error("tick count moved without a tick word");

endmodule
